FILE: hdl/rv32im_instruction_execute_macros.svh
// Assertion macros for the RV32IM execute block
`ifndef RV32IM_INSTRUCTION_EXECUTE_MACROS_SVH
`define RV32IM_INSTRUCTION_EXECUTE_MACROS_SVH
// assert that a implies b on the same edge
`define RVX_ASSERT_IMPL(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b on the following edge
`define RVX_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

FILE: hdl/rvx_pkg.sv
// Shared types and constants for the RV32IM execute block
package rvx_pkg;
  localparam int REG_COUNT = 32;
  localparam int XLEN = 32;
  localparam int RIDX_W = 5;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_ILLEGAL = 4'd1;
  localparam logic [3:0] ST_LOAD_MIS = 4'd2;
  localparam logic [3:0] ST_STORE_MIS = 4'd3;
  localparam logic [3:0] ST_JUMP_MIS = 4'd4;
  localparam logic [3:0] ST_ECALL = 4'd5;
  localparam logic [3:0] ST_EBREAK = 4'd6;
  localparam logic [3:0] ST_SYSTEM = 4'd7;
  localparam logic [3:0] ST_HALT = 4'd8;
  localparam logic [3:0] ST_LOAD_PEND = 4'd9;

  localparam logic [6:0] OP_LUI = 7'h37;
  localparam logic [6:0] OP_AUIPC = 7'h17;
  localparam logic [6:0] OP_LOAD = 7'h03;
  localparam logic [6:0] OP_STORE = 7'h23;
  localparam logic [6:0] OP_IMM = 7'h13;
  localparam logic [6:0] OP_REG = 7'h33;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL = 7'h6f;
  localparam logic [6:0] OP_JALR = 7'h67;
  localparam logic [6:0] OP_FENCE = 7'h0f;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [6:0] OP_HALT = 7'h6b;

  localparam logic [0:0] ACT_EXEC = 1'b0;
  localparam logic [0:0] ACT_LOAD = 1'b1;

  localparam logic [31:0] UIMM_MASK = 32'hfffff000;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_WRITE, S_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] current_pc;
    logic [31:0] next_pc;
    logic [3:0]  status;
    logic [31:0] trap_value;
    logic        mem_read;
    logic        mem_write;
    logic [1:0]  mem_size;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic        write_enable;
    logic [4:0]  write_index;
    logic [31:0] write_value;
  } result_t;

  typedef struct packed {
    logic        start;
    logic        signed_op;
    logic        rem;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } div_rsp_t;
endpackage

FILE: hdl/rvx_if.sv
// Valid/ready channel interfaces for requests and results
interface rvx_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [0:0]  action;
  logic [31:0] instruction;
  logic [31:0] load_data;
  modport source (output valid, action, instruction, load_data, input ready);
  modport sink (input valid, action, instruction, load_data, output ready);
endinterface

interface rvx_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] current_pc;
  logic [31:0] next_pc;
  logic [3:0]  status;
  logic [31:0] trap_value;
  logic        mem_read;
  logic        mem_write;
  logic [1:0]  mem_size;
  logic [31:0] mem_address;
  logic [31:0] store_data;
  logic        write_enable;
  logic [4:0]  write_index;
  logic [31:0] write_value;
  modport source (output valid, current_pc, next_pc, status, trap_value, mem_read, mem_write,
                  mem_size, mem_address, store_data, write_enable, write_index,
                  write_value, input ready);
  modport sink (input valid, current_pc, next_pc, status, trap_value, mem_read, mem_write,
                mem_size, mem_address, store_data, write_enable, write_index,
                write_value, output ready);
endinterface

FILE: hdl/rvx_ram.sv
// Generic single-write, two-read RAM with registered read data
module rvx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

FILE: hdl/rvx_div.sv
// Radix-2 restoring divider for DIV, DIVU, REM and REMU
module rvx_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rvx_pkg::div_req_t req,
  output rvx_pkg::div_rsp_t rsp
);
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic        negq_r, negq_nxt;
  logic        negr_r, negr_nxt;
  logic        isrem_r, isrem_nxt;
  logic [32:0] trial;
  logic [31:0] ua, ub;

  always_comb begin
    ua = (req.signed_op && req.a[31]) ? (32'd0 - req.a) : req.a;
    ub = (req.signed_op && req.b[31]) ? (32'd0 - req.b) : req.b;
    trial = {rem_r, quo_r[31]} - {1'b0, den_r};
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    negq_nxt = negq_r;
    negr_nxt = negr_r;
    isrem_nxt = isrem_r;
    rsp.done = 1'b0;
    rsp.value = 32'd0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 6'd0;
      quo_nxt = ua;
      rem_nxt = 32'd0;
      den_nxt = ub;
      negq_nxt = req.signed_op && (req.a[31] != req.b[31]);
      negr_nxt = req.signed_op && req.a[31];
      isrem_nxt = req.rem;
    end else if (busy_r) begin
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0;
        rsp.done = 1'b1;
        if (isrem_r) begin
          rsp.value = negr_r ? (32'd0 - rem_r) : rem_r;
        end else begin
          rsp.value = negq_r ? (32'd0 - quo_r) : quo_r;
        end
      end else begin
        cnt_nxt = cnt_r + 6'd1;
        if (!trial[32]) begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[30:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
    isrem_r <= isrem_nxt;
  end
endmodule

FILE: hdl/rv32im_instruction_execute.sv
// Top level of the RV32IM execute block: register file RAM, decode and sequencing
//  channel | dir | handshake          | payload
//  in_     | in  | valid/ready        | action, instruction, load_data
//  out_    | out | valid/ready        | pc, status, memory request, register write
//  cfg_    | in  | APB, pready high   | reset_vector at address 0
// Most requests pass through accept, register file read, execute, write and result states.
// DIV/DIVU/REM/REMU wait in S_DIV on the shared divider, bar divide by 0 and overflow.
// Reset clears all 32 register file entries in turn, no request taken meanwhile.
// A result waits in the output register while out_ready is low; the next request
// is taken in the cycle after the result leaves.
`include "rv32im_instruction_execute_macros.svh"
module rv32im_instruction_execute (
  input  logic        clk,
  input  logic        rst_n,
  rvx_in_if.sink      in_ch,
  rvx_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int AW = $clog2(rvx_pkg::REG_COUNT);

  rvx_pkg::state_t state_r, state_nxt;
  logic [31:0] rvec_r, pc_r, pc_nxt;
  logic        lw_r, lw_nxt;
  logic [4:0]  ld_dest_r, ld_dest_nxt;
  logic [1:0]  ld_width_r, ld_width_nxt;
  logic        ld_sx_r, ld_sx_nxt;
  logic [0:0]  act_r;
  logic [31:0] ins_r, ldd_r;
  logic [AW:0] clr_r;
  logic        clr_done;
  rvx_pkg::result_t res_r, res_nxt;
  logic        is_div_r, is_div_nxt;
  logic        cfg_wr;

  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0] ram_wdata, rd_a, rd_b;
  logic [31:0] a, b;

  rvx_pkg::div_req_t dreq;
  rvx_pkg::div_rsp_t drsp;

  logic [6:0] op;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] rd, rs1, rs2;
  logic [31:0] immi, imms, immb, immj, t, alu_b, alu_v, md_v;
  logic [63:0] prod;
  logic        ok1, ok2, ok3, tk, alt;
  logic [3:0]  st;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = rvec_r;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 2'd0);
  assign clr_done = clr_r[AW];

  assign in_ch.ready = (state_r == rvx_pkg::S_IDLE) && clr_done;
  assign out_ch.valid = (state_r == rvx_pkg::S_OUT);
  assign out_ch.current_pc = res_r.current_pc;
  assign out_ch.next_pc = res_r.next_pc;
  assign out_ch.status = res_r.status;
  assign out_ch.trap_value = res_r.trap_value;
  assign out_ch.mem_read = res_r.mem_read;
  assign out_ch.mem_write = res_r.mem_write;
  assign out_ch.mem_size = res_r.mem_size;
  assign out_ch.mem_address = res_r.mem_address;
  assign out_ch.store_data = res_r.store_data;
  assign out_ch.write_enable = res_r.write_enable;
  assign out_ch.write_index = res_r.write_index;
  assign out_ch.write_value = res_r.write_value;

  rvx_ram #(.WIDTH(32), .DEPTH(rvx_pkg::REG_COUNT)) u_rf (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr_a(ins_r[15+:AW]), .raddr_b(ins_r[20+:AW]),
    .rdata_a(rd_a), .rdata_b(rd_b)
  );

  rvx_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    op = ins_r[6:0];
    f3 = ins_r[14:12];
    f7 = ins_r[31:25];
    rd = ins_r[11:7];
    rs1 = ins_r[19:15];
    rs2 = ins_r[24:20];
    a = (rs1 == 5'd0) ? 32'd0 : rd_a;
    b = (rs2 == 5'd0) ? 32'd0 : rd_b;
    immi = {{20{ins_r[31]}}, ins_r[31:20]};
    imms = {{20{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
    immb = {{19{ins_r[31]}}, ins_r[31], ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
    immj = {{11{ins_r[31]}}, ins_r[31], ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};
    ok1 = 32'(rd) < rvx_pkg::REG_COUNT;
    ok2 = 32'(rs1) < rvx_pkg::REG_COUNT;
    ok3 = 32'(rs2) < rvx_pkg::REG_COUNT;
  end

  always_comb begin
    alu_b = (op == rvx_pkg::OP_IMM) ? immi : b;
    alt = (op == rvx_pkg::OP_IMM) ? (f3 == 3'd5 && f7 == 7'h20) : (f7 == 7'h20);
    case (f3)
      3'd0: alu_v = alt ? a - alu_b : a + alu_b;
      3'd1: alu_v = a << alu_b[4:0];
      3'd2: alu_v = {31'd0, $signed(a) < $signed(alu_b)};
      3'd3: alu_v = {31'd0, a < alu_b};
      3'd4: alu_v = a ^ alu_b;
      3'd5: alu_v = alt ? 32'($signed(a) >>> alu_b[4:0]) : a >> alu_b[4:0];
      3'd6: alu_v = a | alu_b;
      default: alu_v = a & alu_b;
    endcase
    case (f3)
      3'd0, 3'd3: prod = {32'd0, a} * {32'd0, b};
      3'd1: prod = 64'($signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b}));
      default: prod = 64'($signed({{32{a[31]}}, a}) * $signed({32'd0, b}));
    endcase
    md_v = (f3 == 3'd0) ? prod[31:0] : prod[63:32];
  end

  always_comb begin
    res_nxt = res_r;
    st = rvx_pkg::ST_OK;
    t = 32'd0;
    tk = 1'b0;
    is_div_nxt = 1'b0;
    dreq.start = 1'b0;
    dreq.signed_op = ~f3[0];
    dreq.rem = f3[1];
    dreq.a = a;
    dreq.b = b;
    pc_nxt = pc_r;
    lw_nxt = lw_r;
    ld_dest_nxt = ld_dest_r;
    ld_width_nxt = ld_width_r;
    ld_sx_nxt = ld_sx_r;
    ram_we = 1'b0;
    ram_waddr = clr_r[AW-1:0];
    ram_wdata = 32'd0;
    if (!clr_done) begin
      ram_we = 1'b1;
    end
    if (state_r == rvx_pkg::S_EXEC) begin
      res_nxt = '0;
      res_nxt.current_pc = pc_r;
      res_nxt.next_pc = pc_r;
      if (act_r == rvx_pkg::ACT_LOAD) begin
        if (lw_r) begin
          unique case (ld_width_r)
            2'd0: t = ld_sx_r ? {{24{ldd_r[7]}}, ldd_r[7:0]} : {24'd0, ldd_r[7:0]};
            2'd1: t = ld_sx_r ? {{16{ldd_r[15]}}, ldd_r[15:0]} : {16'd0, ldd_r[15:0]};
            default: t = ldd_r;
          endcase
          res_nxt.write_enable = 1'b1;
          res_nxt.write_index = ld_dest_r;
          res_nxt.write_value = t;
          res_nxt.next_pc = pc_r + 32'd4;
          lw_nxt = 1'b0;
        end
      end else if (lw_r) begin
        st = rvx_pkg::ST_LOAD_PEND;
      end else begin
        res_nxt.next_pc = pc_r + 32'd4;
        unique case (op)
          rvx_pkg::OP_LUI: begin
            if (!ok1) st = rvx_pkg::ST_ILLEGAL;
            else begin
              res_nxt.write_enable = 1'b1;
              res_nxt.write_index = rd;
              res_nxt.write_value = ins_r & rvx_pkg::UIMM_MASK;
            end
          end
          rvx_pkg::OP_AUIPC: begin
            if (!ok1) st = rvx_pkg::ST_ILLEGAL;
            else begin
              res_nxt.write_enable = 1'b1;
              res_nxt.write_index = rd;
              res_nxt.write_value = pc_r + (ins_r & rvx_pkg::UIMM_MASK);
            end
          end
          rvx_pkg::OP_LOAD: begin
            t = a + immi;
            if (f3 == 3'd3 || f3 > 3'd5 || !ok1 || !ok2) st = rvx_pkg::ST_ILLEGAL;
            else if ((f3[1:0] == 2'd1 && t[0]) || (f3[1:0] == 2'd2 && t[1:0] != 2'd0)) begin
              st = rvx_pkg::ST_LOAD_MIS;
              res_nxt.trap_value = t;
            end else begin
              st = rvx_pkg::ST_LOAD_PEND;
              res_nxt.mem_read = 1'b1;
              res_nxt.mem_size = f3[1:0];
              res_nxt.mem_address = t;
              res_nxt.next_pc = pc_r;
              lw_nxt = 1'b1;
              ld_dest_nxt = rd;
              ld_width_nxt = f3[1:0];
              ld_sx_nxt = ~f3[2];
            end
          end
          rvx_pkg::OP_STORE: begin
            t = a + imms;
            if (f3 > 3'd2 || !ok2 || !ok3) st = rvx_pkg::ST_ILLEGAL;
            else if ((f3 == 3'd1 && t[0]) || (f3 == 3'd2 && t[1:0] != 2'd0)) begin
              st = rvx_pkg::ST_STORE_MIS;
              res_nxt.trap_value = t;
            end else begin
              res_nxt.mem_write = 1'b1;
              res_nxt.mem_size = f3[1:0];
              res_nxt.mem_address = t;
              res_nxt.store_data = b;
            end
          end
          rvx_pkg::OP_IMM: begin
            if ((f3 == 3'd1 && f7 != 7'd0) || (f3 == 3'd5 && f7 != 7'd0 && f7 != 7'h20)
                || !ok1 || !ok2) st = rvx_pkg::ST_ILLEGAL;
            else begin
              res_nxt.write_enable = 1'b1;
              res_nxt.write_index = rd;
              res_nxt.write_value = alu_v;
            end
          end
          rvx_pkg::OP_REG: begin
            if (!ok1 || !ok2 || !ok3) st = rvx_pkg::ST_ILLEGAL;
            else if (f7 == 7'd1) begin
              res_nxt.write_enable = 1'b1;
              res_nxt.write_index = rd;
              if (f3[2]) begin
                if (b == 32'd0) begin
                  res_nxt.write_value = f3[1] ? a : 32'hffffffff;
                end else if (!f3[0] && a == 32'h80000000 && b == 32'hffffffff) begin
                  res_nxt.write_value = f3[1] ? 32'd0 : a;
                end else begin
                  is_div_nxt = 1'b1;
                  dreq.start = 1'b1;
                end
              end else begin
                res_nxt.write_value = md_v;
              end
            end else if (f7 == 7'd0 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5))) begin
              res_nxt.write_enable = 1'b1;
              res_nxt.write_index = rd;
              res_nxt.write_value = alu_v;
            end else st = rvx_pkg::ST_ILLEGAL;
          end
          rvx_pkg::OP_BRANCH: begin
            t = pc_r + immb;
            case (f3)
              3'd0, 3'd1: tk = (a == b) != f3[0];
              3'd4, 3'd5: tk = ($signed(a) < $signed(b)) != f3[0];
              default: tk = (a < b) != f3[0];
            endcase
            if (f3 == 3'd2 || f3 == 3'd3 || !ok2 || !ok3) st = rvx_pkg::ST_ILLEGAL;
            else if (tk) begin
              if (t[1:0] != 2'd0) begin
                st = rvx_pkg::ST_JUMP_MIS;
                res_nxt.trap_value = t;
              end else res_nxt.next_pc = t;
            end
          end
          rvx_pkg::OP_JAL: begin
            t = pc_r + immj;
            if (!ok1) st = rvx_pkg::ST_ILLEGAL;
            else if (t[1:0] != 2'd0) begin
              st = rvx_pkg::ST_JUMP_MIS;
              res_nxt.trap_value = t;
            end else begin
              res_nxt.write_enable = 1'b1;
              res_nxt.write_index = rd;
              res_nxt.write_value = pc_r + 32'd4;
              res_nxt.next_pc = t;
            end
          end
          rvx_pkg::OP_JALR: begin
            t = (a + immi) & ~32'd1;
            if (f3 != 3'd0 || !ok1 || !ok2) st = rvx_pkg::ST_ILLEGAL;
            else if (t[1] != 1'b0) begin
              st = rvx_pkg::ST_JUMP_MIS;
              res_nxt.trap_value = t;
            end else begin
              res_nxt.write_enable = 1'b1;
              res_nxt.write_index = rd;
              res_nxt.write_value = pc_r + 32'd4;
              res_nxt.next_pc = t;
            end
          end
          rvx_pkg::OP_FENCE: begin
            if (f3 > 3'd1) st = rvx_pkg::ST_ILLEGAL;
          end
          rvx_pkg::OP_SYSTEM: begin
            if (ins_r == 32'h00000073) st = rvx_pkg::ST_ECALL;
            else if (ins_r == 32'h00100073) st = rvx_pkg::ST_EBREAK;
            else if (ins_r == 32'h30200073 || ins_r == 32'h10500073) st = rvx_pkg::ST_SYSTEM;
            else if ((ins_r & 32'hfe007fff) == 32'h12000073)
              st = (ok2 && ok3) ? rvx_pkg::ST_SYSTEM : rvx_pkg::ST_ILLEGAL;
            else if (f3 >= 3'd1 && f3 <= 3'd3)
              st = (ok1 && ok2) ? rvx_pkg::ST_SYSTEM : rvx_pkg::ST_ILLEGAL;
            else if (f3 >= 3'd5) st = ok1 ? rvx_pkg::ST_SYSTEM : rvx_pkg::ST_ILLEGAL;
            else st = rvx_pkg::ST_ILLEGAL;
          end
          rvx_pkg::OP_HALT: st = rvx_pkg::ST_HALT;
          default: st = rvx_pkg::ST_ILLEGAL;
        endcase
        if ((st >= rvx_pkg::ST_ILLEGAL && st <= rvx_pkg::ST_EBREAK) || st == rvx_pkg::ST_HALT) begin
          res_nxt.next_pc = pc_r;
          res_nxt.write_enable = 1'b0;
          res_nxt.mem_read = 1'b0;
          res_nxt.mem_write = 1'b0;
          res_nxt.mem_size = 2'd0;
          res_nxt.mem_address = 32'd0;
          res_nxt.store_data = 32'd0;
          is_div_nxt = 1'b0;
          dreq.start = 1'b0;
        end
      end
      res_nxt.status = st;
    end
    if (state_r == rvx_pkg::S_DIV && drsp.done) begin
      res_nxt.write_value = drsp.value;
    end
    if (state_r == rvx_pkg::S_WRITE) begin
      if (res_r.write_enable && res_r.write_index != 5'd0) begin
        ram_we = 1'b1;
        ram_waddr = res_r.write_index[AW-1:0];
        ram_wdata = res_r.write_value;
      end else begin
        res_nxt.write_enable = 1'b0;
        res_nxt.write_index = 5'd0;
        res_nxt.write_value = 32'd0;
      end
      pc_nxt = res_r.next_pc;
    end
    if (cfg_wr) begin
      pc_nxt = cfg_pwdata;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rvx_pkg::S_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = rvx_pkg::S_READ;
      rvx_pkg::S_READ: state_nxt = rvx_pkg::S_EXEC;
      rvx_pkg::S_EXEC: state_nxt = is_div_nxt ? rvx_pkg::S_DIV : rvx_pkg::S_WRITE;
      rvx_pkg::S_DIV: if (drsp.done) state_nxt = rvx_pkg::S_WRITE;
      rvx_pkg::S_WRITE: state_nxt = rvx_pkg::S_OUT;
      rvx_pkg::S_OUT: if (out_ch.ready) state_nxt = rvx_pkg::S_IDLE;
      default: state_nxt = rvx_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rvx_pkg::S_IDLE;
      rvec_r <= 32'h80000000;
      pc_r <= 32'h80000000;
      lw_r <= 1'b0;
      ld_dest_r <= 5'd0;
      ld_width_r <= 2'd0;
      ld_sx_r <= 1'b0;
      clr_r <= '0;
      is_div_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) rvec_r <= cfg_pwdata;
      pc_r <= pc_nxt;
      lw_r <= lw_nxt;
      ld_dest_r <= ld_dest_nxt;
      ld_width_r <= ld_width_nxt;
      ld_sx_r <= ld_sx_nxt;
      if (!clr_done) clr_r <= clr_r + 1'b1;
      if (state_r == rvx_pkg::S_EXEC) is_div_r <= is_div_nxt;
    end
    if (in_ch.valid && in_ch.ready) begin
      act_r <= in_ch.action;
      ins_r <= in_ch.instruction;
      ldd_r <= in_ch.load_data;
    end
    res_r <= res_nxt;
  end

  `RVX_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, in_ch.valid && in_ch.ready, !out_ch.valid)
  `RVX_ASSERT_IMPL(a_div_only_when_flagged, clk, rst_n, state_r == rvx_pkg::S_DIV, is_div_r)
  `RVX_ASSERT_NEXT(a_out_holds, clk, rst_n, out_ch.valid && !out_ch.ready,
                   out_ch.valid && $stable(out_ch.next_pc) && $stable(out_ch.status))
endmodule

FILE: tb/sv/tb_rv32im_instruction_execute.sv
// Self-checking testbench for the RV32IM execute block: directed and random instruction streams
`timescale 1ns / 100ps
module tb_rv32im_instruction_execute;

  localparam int LIMIT = 600000;
  localparam int DRAIN_WAIT = 45;
  localparam int RANDOM_PER_PHASE = 250;
  localparam logic [1:0] REG_RESET_VECTOR = 2'd0;
  localparam logic [31:0] W_ECALL = 32'h00000073;
  localparam logic [31:0] W_EBREAK = 32'h00100073;
  localparam logic [31:0] W_MRET = 32'h30200073;
  localparam logic [31:0] W_WFI = 32'h10500073;
  localparam logic [31:0] SFENCE_MASK = 32'hfe007fff;
  localparam logic [31:0] SFENCE_VAL = 32'h12000073;
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT = 7'h20;

  class core_scoreboard;
    logic [31:0] regs [32];
    logic [31:0] pc;
    logic ld_wait;
    logic [4:0] ld_dest;
    logic [1:0] ld_w;
    logic ld_sx;
    rvx_pkg::result_t pending_q[$];
    int errors;
    int checked;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc = 32'h80000000;
      ld_wait = 0; ld_dest = 0; ld_w = 0; ld_sx = 0;
      errors = 0; checked = 0;
    endfunction

    function logic [31:0] alu(logic [2:0] f3, logic alt, logic [31:0] a, logic [31:0] b);
      case (f3)
        3'd0: return alt ? a - b : a + b;
        3'd1: return a << b[4:0];
        3'd2: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        3'd3: return (a < b) ? 32'd1 : 32'd0;
        3'd4: return a ^ b;
        3'd5: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
        3'd6: return a | b;
        default: return a & b;
      endcase
    endfunction

    function logic [31:0] muldiv(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
      logic [63:0] p;
      logic signed [31:0] sa, sb;
      sa = a; sb = b;
      case (f3)
        3'd0: return a * b;
        3'd1: begin
          p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
          return p[63:32];
        end
        3'd2: begin
          p = {{32{a[31]}}, a} * {32'd0, b};
          return p[63:32];
        end
        3'd3: begin
          p = {32'd0, a} * {32'd0, b};
          return p[63:32];
        end
        3'd4: begin
          if (b == 0) return 32'hffffffff;
          if (a == 32'h80000000 && b == 32'hffffffff) return a;
          return 32'(sa / sb);
        end
        3'd5: return (b == 0) ? 32'hffffffff : a / b;
        3'd6: begin
          if (b == 0) return a;
          if (a == 32'h80000000 && b == 32'hffffffff) return 32'd0;
          return 32'(sa % sb);
        end
        default: return (b == 0) ? a : a % b;
      endcase
    endfunction

    function void set_pc(logic [31:0] v);
      pc = v;
    endfunction

    function void note_request(logic act, logic [31:0] ins, logic [31:0] dat);
      rvx_pkg::result_t r;
      logic [6:0] op, f7;
      logic [2:0] f3;
      logic [4:0] rd;
      logic [31:0] a, b, immi, imms, immb, immj, t;
      logic tk;
      r = '0;
      r.current_pc = pc;
      r.next_pc = pc;
      if (act == rvx_pkg::ACT_LOAD) begin
        if (ld_wait) begin
          case (ld_w)
            2'd0: t = ld_sx ? {{24{dat[7]}}, dat[7:0]} : {24'd0, dat[7:0]};
            2'd1: t = ld_sx ? {{16{dat[15]}}, dat[15:0]} : {16'd0, dat[15:0]};
            default: t = dat;
          endcase
          r.write_enable = 1; r.write_index = ld_dest; r.write_value = t;
          r.next_pc = pc + 4;
          ld_wait = 0;
        end
      end else if (ld_wait) begin
        r.status = rvx_pkg::ST_LOAD_PEND;
      end else begin
        op = ins[6:0]; f3 = ins[14:12]; f7 = ins[31:25]; rd = ins[11:7];
        a = regs[ins[19:15]]; b = regs[ins[24:20]];
        immi = {{20{ins[31]}}, ins[31:20]};
        imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        r.next_pc = pc + 4;
        case (op)
          rvx_pkg::OP_LUI: begin
            r.write_enable = 1; r.write_index = rd; r.write_value = ins & rvx_pkg::UIMM_MASK;
          end
          rvx_pkg::OP_AUIPC: begin
            r.write_enable = 1; r.write_index = rd;
            r.write_value = pc + (ins & rvx_pkg::UIMM_MASK);
          end
          rvx_pkg::OP_LOAD: begin
            t = a + immi;
            if (f3 == 3'd3 || f3 > 3'd5) r.status = rvx_pkg::ST_ILLEGAL;
            else if ((f3[1:0] == 2'd1 && t[0]) || (f3[1:0] == 2'd2 && t[1:0] != 0)) begin
              r.status = rvx_pkg::ST_LOAD_MIS; r.trap_value = t;
            end else begin
              r.status = rvx_pkg::ST_LOAD_PEND; r.mem_read = 1; r.mem_size = f3[1:0];
              r.mem_address = t; r.next_pc = pc;
              ld_wait = 1; ld_dest = rd; ld_w = f3[1:0]; ld_sx = !f3[2];
            end
          end
          rvx_pkg::OP_STORE: begin
            t = a + imms;
            if (f3 > 3'd2) r.status = rvx_pkg::ST_ILLEGAL;
            else if ((f3 == 3'd1 && t[0]) || (f3 == 3'd2 && t[1:0] != 0)) begin
              r.status = rvx_pkg::ST_STORE_MIS; r.trap_value = t;
            end else begin
              r.mem_write = 1; r.mem_size = f3[1:0]; r.mem_address = t; r.store_data = b;
            end
          end
          rvx_pkg::OP_IMM: begin
            if ((f3 == 3'd1 && f7 != F7_BASE) ||
                (f3 == 3'd5 && f7 != F7_BASE && f7 != F7_ALT)) r.status = rvx_pkg::ST_ILLEGAL;
            else begin
              r.write_enable = 1; r.write_index = rd;
              r.write_value = alu(f3, f3 == 3'd5 && f7 == F7_ALT, a, immi);
            end
          end
          rvx_pkg::OP_REG: begin
            r.write_enable = 1; r.write_index = rd;
            if (f7 == F7_MULDIV) r.write_value = muldiv(f3, a, b);
            else if (f7 == F7_BASE) r.write_value = alu(f3, 1'b0, a, b);
            else if (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))
              r.write_value = alu(f3, 1'b1, a, b);
            else r.status = rvx_pkg::ST_ILLEGAL;
          end
          rvx_pkg::OP_BRANCH: begin
            case (f3)
              3'd0: tk = a == b;
              3'd1: tk = a != b;
              3'd4: tk = $signed(a) < $signed(b);
              3'd5: tk = !($signed(a) < $signed(b));
              3'd6: tk = a < b;
              default: tk = !(a < b);
            endcase
            t = pc + immb;
            if (f3 == 3'd2 || f3 == 3'd3) r.status = rvx_pkg::ST_ILLEGAL;
            else if (tk && t[1:0] != 0) begin
              r.status = rvx_pkg::ST_JUMP_MIS; r.trap_value = t;
            end else if (tk) r.next_pc = t;
          end
          rvx_pkg::OP_JAL: begin
            t = pc + immj;
            if (t[1:0] != 0) begin
              r.status = rvx_pkg::ST_JUMP_MIS; r.trap_value = t;
            end else begin
              r.write_enable = 1; r.write_index = rd; r.write_value = pc + 4; r.next_pc = t;
            end
          end
          rvx_pkg::OP_JALR: begin
            t = (a + immi) & ~32'd1;
            if (f3 != 0) r.status = rvx_pkg::ST_ILLEGAL;
            else if (t[1:0] != 0) begin
              r.status = rvx_pkg::ST_JUMP_MIS; r.trap_value = t;
            end else begin
              r.write_enable = 1; r.write_index = rd; r.write_value = pc + 4; r.next_pc = t;
            end
          end
          rvx_pkg::OP_FENCE: if (f3 > 3'd1) r.status = rvx_pkg::ST_ILLEGAL;
          rvx_pkg::OP_SYSTEM: begin
            if (ins == W_ECALL) r.status = rvx_pkg::ST_ECALL;
            else if (ins == W_EBREAK) r.status = rvx_pkg::ST_EBREAK;
            else if (ins == W_MRET || ins == W_WFI) r.status = rvx_pkg::ST_SYSTEM;
            else if ((ins & SFENCE_MASK) == SFENCE_VAL) r.status = rvx_pkg::ST_SYSTEM;
            else if ((f3 >= 3'd1 && f3 <= 3'd3) || f3 >= 3'd5) r.status = rvx_pkg::ST_SYSTEM;
            else r.status = rvx_pkg::ST_ILLEGAL;
          end
          rvx_pkg::OP_HALT: r.status = rvx_pkg::ST_HALT;
          default: r.status = rvx_pkg::ST_ILLEGAL;
        endcase
        if ((r.status >= rvx_pkg::ST_ILLEGAL && r.status <= rvx_pkg::ST_EBREAK) ||
            r.status == rvx_pkg::ST_HALT) begin
          r.next_pc = pc; r.write_enable = 0; r.mem_read = 0; r.mem_write = 0;
          r.mem_size = 0; r.mem_address = 0; r.store_data = 0;
        end
      end
      if (r.write_enable && r.write_index != 0) regs[r.write_index] = r.write_value;
      else begin
        r.write_enable = 0; r.write_index = 0; r.write_value = 0;
      end
      pc = r.next_pc;
      pending_q.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] g);
      if (e !== g) begin
        $error("%s: expected %h, got %h", name, e, g);
        errors++;
      end
    endfunction

    function void check_result(rvx_pkg::result_t g);
      rvx_pkg::result_t e;
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding, pc %h", g.current_pc);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      cmp("current_pc", e.current_pc, g.current_pc);
      cmp("next_pc", e.next_pc, g.next_pc);
      cmp("status", e.status, g.status);
      cmp("trap_value", e.trap_value, g.trap_value);
      cmp("mem_read", e.mem_read, g.mem_read);
      cmp("mem_write", e.mem_write, g.mem_write);
      cmp("mem_size", e.mem_size, g.mem_size);
      cmp("mem_address", e.mem_address, g.mem_address);
      cmp("store_data", e.store_data, g.store_data);
      cmp("write_enable", e.write_enable, g.write_enable);
      cmp("write_index", e.write_index, g.write_index);
      cmp("write_value", e.write_value, g.write_value);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  rvx_in_if in_ch (clk);
  rvx_out_if out_ch (clk);

  rv32im_instruction_execute dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  core_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int n_requests = 0;
  int n_cfg = 0;
  int cycles = 0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[rv32im_instruction_execute] ERROR");
      $finish;
    end
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.current_pc, out_ch.next_pc, out_ch.status, out_ch.trap_value,
                       out_ch.mem_read, out_ch.mem_write, out_ch.mem_size, out_ch.mem_address,
                       out_ch.store_data, out_ch.write_enable, out_ch.write_index,
                       out_ch.write_value});
  end

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rvx_pkg::OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rvx_pkg::OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rvx_pkg::OP_JAL};
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [11:0] imm;
    logic [6:0] f7;
    rd = 5'($urandom_range(31));
    rs1 = ($urandom_range(2) == 0) ? 5'd0 : 5'($urandom_range(31));
    rs2 = 5'($urandom_range(31));
    f3 = 3'($urandom_range(7));
    imm = ($urandom_range(1) == 0) ? 12'($urandom) : 12'($urandom_range(63) << 2);
    case ($urandom_range(15))
      0: return {20'($urandom), rd, rvx_pkg::OP_LUI};
      1: return {20'($urandom), rd, rvx_pkg::OP_AUIPC};
      2, 3: begin
        if (f3 == 3'd1 || f3 == 3'd5)
          imm[11:5] = ($urandom_range(7) == 0) ? 7'($urandom) :
                      ($urandom_range(1) ? F7_ALT : F7_BASE);
        return enc_i(imm, rs1, f3, rd, rvx_pkg::OP_IMM);
      end
      4: begin
        case ($urandom_range(3))
          0: f7 = F7_BASE;
          1: f7 = F7_ALT;
          2: f7 = F7_MULDIV;
          default: f7 = 7'($urandom);
        endcase
        return enc_r(f7, rs2, rs1, f3, rd, rvx_pkg::OP_REG);
      end
      5, 6: return enc_r(F7_MULDIV, rs2, rs1, f3, rd, rvx_pkg::OP_REG);
      7, 8: return enc_i(imm, rs1, ($urandom_range(5) == 0) ? f3 : 3'($urandom_range(2)) |
                         ($urandom_range(1) ? 3'd4 : 3'd0), rd, rvx_pkg::OP_LOAD);
      9: return enc_s(imm, rs2, rs1, ($urandom_range(5) == 0) ? f3 : 3'($urandom_range(2)));
      10: return enc_b(($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(255) << 2),
                       rs2, rs1, f3);
      11: return enc_j(($urandom_range(3) == 0) ? 21'($urandom) : 21'($urandom_range(4095) << 2),
                       rd);
      12: return enc_i(imm, rs1, ($urandom_range(5) == 0) ? f3 : 3'd0, rd, rvx_pkg::OP_JALR);
      13: begin
        case ($urandom_range(6))
          0: return W_ECALL;
          1: return W_EBREAK;
          2: return W_MRET;
          3: return W_WFI;
          4: return {7'h09, rs2, rs1, 3'd0, 5'd0, rvx_pkg::OP_SYSTEM};
          default: return {12'($urandom), rs1, f3, rd, rvx_pkg::OP_SYSTEM};
        endcase
      end
      14: return ($urandom_range(1) == 0) ? {25'($urandom), rvx_pkg::OP_HALT} :
                 enc_i(imm, rs1, f3, rd, rvx_pkg::OP_FENCE);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic act, logic [31:0] ins, logic [31:0] dat);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.action <= act;
    in_ch.instruction <= ins;
    in_ch.load_data <= dat;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_request(act, ins, dat);
    n_requests++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reset_vector(logic [31:0] v);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= REG_RESET_VECTOR; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_pc(v);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
    n_cfg++;
  endtask

  task automatic run_directed();
    send(rvx_pkg::ACT_EXEC, {20'h80000, 5'd1, rvx_pkg::OP_LUI}, 0);
    send(rvx_pkg::ACT_EXEC, enc_i(12'hfff, 5'd0, 3'd0, 5'd2, rvx_pkg::OP_IMM), 0);
    send(rvx_pkg::ACT_EXEC, enc_r(F7_MULDIV, 5'd2, 5'd1, 3'd4, 5'd3, rvx_pkg::OP_REG), 0);
    send(rvx_pkg::ACT_EXEC, enc_r(F7_MULDIV, 5'd2, 5'd1, 3'd6, 5'd4, rvx_pkg::OP_REG), 0);
    send(rvx_pkg::ACT_EXEC, enc_r(F7_MULDIV, 5'd0, 5'd1, 3'd5, 5'd5, rvx_pkg::OP_REG), 0);
    send(rvx_pkg::ACT_EXEC, enc_r(F7_MULDIV, 5'd0, 5'd1, 3'd7, 5'd6, rvx_pkg::OP_REG), 0);
    send(rvx_pkg::ACT_EXEC, enc_r(F7_MULDIV, 5'd2, 5'd1, 3'd1, 5'd7, rvx_pkg::OP_REG), 0);
    send(rvx_pkg::ACT_EXEC, enc_r(F7_MULDIV, 5'd1, 5'd2, 3'd2, 5'd8, rvx_pkg::OP_REG), 0);
    send(rvx_pkg::ACT_EXEC, enc_r(F7_MULDIV, 5'd2, 5'd2, 3'd3, 5'd9, rvx_pkg::OP_REG), 0);
    send(rvx_pkg::ACT_EXEC, enc_r(F7_ALT, 5'd2, 5'd1, 3'd5, 5'd0, rvx_pkg::OP_REG), 0);
    send(rvx_pkg::ACT_EXEC, enc_s(12'd0, 5'd1, 5'd0, 3'd2), 0);
    send(rvx_pkg::ACT_EXEC, enc_i(12'd2, 5'd0, 3'd2, 5'd10, rvx_pkg::OP_LOAD), 0);
    send(rvx_pkg::ACT_EXEC, enc_i(12'd3, 5'd0, 3'd0, 5'd11, rvx_pkg::OP_LOAD), 0);
    send(rvx_pkg::ACT_LOAD, 0, 32'h12345680);
    send(rvx_pkg::ACT_EXEC, enc_i(12'd2, 5'd0, 3'd5, 5'd12, rvx_pkg::OP_LOAD), 0);
    send(rvx_pkg::ACT_EXEC, {20'h12345, 5'd13, rvx_pkg::OP_LUI}, 0);
    send(rvx_pkg::ACT_LOAD, 32'hffffffff, 32'hffff8001);
    send(rvx_pkg::ACT_LOAD, 32'hffffffff, 32'hffffffff);
    send(rvx_pkg::ACT_EXEC, W_ECALL, 0);
    send(rvx_pkg::ACT_EXEC, W_EBREAK, 0);
    send(rvx_pkg::ACT_EXEC, W_MRET, 0);
    send(rvx_pkg::ACT_EXEC, W_WFI, 0);
    send(rvx_pkg::ACT_EXEC, {25'd0, rvx_pkg::OP_HALT}, 0);
    send(rvx_pkg::ACT_EXEC, enc_i(12'd0, 5'd0, 3'd0, 5'd0, rvx_pkg::OP_FENCE), 0);
    send(rvx_pkg::ACT_EXEC, 32'hffffffff, 0);
    send(rvx_pkg::ACT_EXEC, enc_j(21'd2, 5'd1), 0);
    send(rvx_pkg::ACT_EXEC, enc_i(12'd1, 5'd0, 3'd0, 5'd0, rvx_pkg::OP_JALR), 0);
    send(rvx_pkg::ACT_EXEC, enc_b(13'd6, 5'd0, 5'd0, 3'd0), 0);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      send(rvx_pkg::ACT_EXEC, rand_instr(), $urandom);
      if (sb.ld_wait) begin
        if ($urandom_range(9) == 0) send(rvx_pkg::ACT_EXEC, $urandom, $urandom);
        send(rvx_pkg::ACT_LOAD, $urandom, $urandom);
      end else if ($urandom_range(29) == 0) begin
        send(rvx_pkg::ACT_LOAD, $urandom, $urandom);
      end
    end
    if (sb.ld_wait) send(rvx_pkg::ACT_LOAD, $urandom, $urandom);
  endtask

  initial begin
    rst_n = 0;
    in_ch.valid = 0; in_ch.action = rvx_pkg::ACT_EXEC; in_ch.instruction = 0;
    in_ch.load_data = 0;
    out_ch.ready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    run_directed();
    drain();

    tx_idle_pct = 11; rx_idle_pct = 69;
    write_reset_vector(32'h00000000);
    run_random(RANDOM_PER_PHASE);
    drain();

    tx_idle_pct = 69; rx_idle_pct = 11;
    write_reset_vector(32'hffffffff);
    run_random(RANDOM_PER_PHASE);
    drain();

    tx_idle_pct = 0; rx_idle_pct = 0;
    write_reset_vector($urandom & ~32'd3);
    run_random(RANDOM_PER_PHASE);
    drain();

    $display("%0d requests sent, %0d results checked, %0d reset vector settings",
             n_requests, sb.checked, n_cfg);
    if (sb.errors == 0) $display("[rv32im_instruction_execute] OK");
    else $display("[rv32im_instruction_execute] ERROR");
    $finish;
  end
endmodule
